@@ hw/rtl/mdsfp_pkg.sv @@
package mdsfp_pkg;

	localparam int unsigned FRAME_LEN = 20;
	localparam int unsigned POS_W     = 5;

	localparam logic [POS_W-1:0] POS_HUNT  = 5'd0;
	localparam logic [POS_W-1:0] POS_SUM_LAST = 5'd16;
	localparam logic [POS_W-1:0] POS_LAST  = 5'(FRAME_LEN - 1);

	localparam logic [7:0] HDR_BYTE  = 8'h55;
	localparam logic [7:0] END_BYTE1 = 8'h0D;
	localparam logic [7:0] END_BYTE2 = 8'h0A;
	localparam logic [7:0] OV_MASK   = 8'h02;
	localparam logic [7:0] UV_MASK   = 8'h01;
	localparam logic [7:0] OC_MASK   = 8'hFC;

	localparam logic [1:0] ST_GOOD    = 2'd0;
	localparam logic [1:0] ST_BAD_END = 2'd1;
	localparam logic [1:0] ST_BAD_SUM = 2'd2;

	localparam logic [1:0] TRK_CLEAR  = 2'd0;
	localparam logic [1:0] TRK_ACTIVE = 2'd1;
	localparam logic [1:0] TRK_ENDED  = 2'd2;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] motor_speed;
		logic [15:0] phase_current;
		logic [7:0]  module_temperature;
		logic [7:0]  motor_temperature;
		logic [7:0]  fault_code_high;
		logic [7:0]  fault_code_low;
		logic [7:0]  drive_version;
	} frame_info_t;

	typedef struct packed {
		logic [1:0]  frame_status;
		logic [15:0] motor_speed;
		logic [15:0] phase_current;
		logic [7:0]  module_temperature;
		logic [7:0]  motor_temperature;
		logic [7:0]  fault_code_high;
		logic [7:0]  fault_code_low;
		logic [7:0]  drive_version;
		logic [1:0]  overvoltage_state;
		logic [1:0]  undervoltage_state;
		logic [1:0]  overcurrent_state;
	} result_t;

	function automatic logic [1:0] track(input logic [1:0] cur, input logic fault);
		logic [1:0] nxt;
		nxt = cur;
		if (fault) begin
			nxt = TRK_ACTIVE;
		end else if (cur == TRK_ACTIVE) begin
			nxt = TRK_ENDED;
		end
		return nxt;
	endfunction

endpackage

@@ hw/rtl/mdsfp_capture.sv @@
module mdsfp_capture
	import mdsfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  rx_byte,
	output logic        at_last,
	output frame_info_t info
);

	logic [POS_W-1:0] pos_q;
	logic [7:0]       sum_q;
	logic [7:0]       b1_q, b2_q, b5_q, b6_q, b7_q, b8_q;
	logic [7:0]       b14_q, b15_q, b16_q, b17_q, b18_q;
	logic             hunting;

	assign hunting = (pos_q == POS_HUNT) || (pos_q > POS_LAST);
	assign at_last = (pos_q == POS_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
			sum_q <= '0;
		end else if (step) begin
			if (hunting) begin
				if (rx_byte == HDR_BYTE) begin
					pos_q <= POS_HUNT + 5'd1;
					sum_q <= rx_byte;
				end else begin
					pos_q <= POS_HUNT;
				end
			end else begin
				if (pos_q <= POS_SUM_LAST) begin
					sum_q <= sum_q + rx_byte;
				end
				if (pos_q < POS_LAST) begin
					pos_q <= pos_q + 5'd1;
				end else begin
					pos_q <= POS_HUNT;
				end
			end
		end
	end

	// only the frame bytes that are decoded or checked are kept
	always_ff @(posedge clk) begin
		if (step && !hunting) begin
			unique case (pos_q)
				5'd1:    b1_q  <= rx_byte;
				5'd2:    b2_q  <= rx_byte;
				5'd5:    b5_q  <= rx_byte;
				5'd6:    b6_q  <= rx_byte;
				5'd7:    b7_q  <= rx_byte;
				5'd8:    b8_q  <= rx_byte;
				5'd14:   b14_q <= rx_byte;
				5'd15:   b15_q <= rx_byte;
				5'd16:   b16_q <= rx_byte;
				5'd17:   b17_q <= rx_byte;
				5'd18:   b18_q <= rx_byte;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (b18_q != END_BYTE1 || rx_byte != END_BYTE2) begin
			info.status = ST_BAD_END;
		end else if (sum_q != b17_q) begin
			info.status = ST_BAD_SUM;
		end else begin
			info.status = ST_GOOD;
		end
		info.motor_speed        = {b1_q, b2_q};
		info.phase_current      = {b5_q, b6_q};
		info.module_temperature = b7_q;
		info.motor_temperature  = b8_q;
		info.fault_code_high    = b14_q;
		info.fault_code_low     = b15_q;
		info.drive_version      = b16_q;
	end

endmodule

@@ hw/rtl/mdsfp_result.sv @@
module mdsfp_result
	import mdsfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic        shield,
	input  frame_info_t info,
	input  logic        out_ready,
	output logic        out_valid,
	output result_t     res
);

	logic [1:0] ov_q, uv_q, oc_q;
	logic [1:0] ov_d, uv_d, oc_d;
	logic       good;
	logic       out_valid_q;
	result_t    res_q;

	assign good = (info.status == ST_GOOD);

	always_comb begin
		ov_d = ov_q;
		uv_d = uv_q;
		oc_d = oc_q;
		if (good) begin
			ov_d = track(ov_q, (info.fault_code_low & OV_MASK) != 8'd0);
			if (!shield) begin
				uv_d = track(uv_q, (info.fault_code_low & UV_MASK) != 8'd0);
				oc_d = track(oc_q, (info.fault_code_low & OC_MASK) != 8'd0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q        <= TRK_CLEAR;
			uv_q        <= TRK_CLEAR;
			oc_q        <= TRK_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				ov_q        <= ov_d;
				uv_q        <= uv_d;
				oc_q        <= oc_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.frame_status       <= info.status;
			res_q.motor_speed        <= good ? info.motor_speed : 16'd0;
			res_q.phase_current      <= good ? info.phase_current : 16'd0;
			res_q.module_temperature <= good ? info.module_temperature : 8'd0;
			res_q.motor_temperature  <= good ? info.motor_temperature : 8'd0;
			res_q.fault_code_high    <= good ? info.fault_code_high : 8'd0;
			res_q.fault_code_low     <= good ? info.fault_code_low : 8'd0;
			res_q.drive_version      <= good ? info.drive_version : 8'd0;
			res_q.overvoltage_state  <= ov_d;
			res_q.undervoltage_state <= uv_d;
			res_q.overcurrent_state  <= oc_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

@@ hw/rtl/motor_drive_status_frame_parser_top.sv @@
// output: the result of a frame is on m_axis_tvalid once byte 19 has passed the input register and the result register
// throughput: one byte per cycle; input stalls only while a finished frame waits at the output
// and byte 19 of the next frame is ready to complete
// reset: arst_n clears the parser to header hunting, the fault trackers to clear and both valids
module motor_drive_status_frame_parser_top
	import mdsfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // rx_byte[7:0], shield_active[8], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// motor_speed[15:0], phase_current[31:16], module_temperature[39:32],
	// motor_temperature[47:40], fault_code_high[55:48], fault_code_low[63:56],
	// drive_version[71:64], overvoltage_state[73:72], undervoltage_state[75:74],
	// overcurrent_state[77:76], zero pad
	output logic [79:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser   // frame_status[1:0]
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        shield_s1;
	logic        at_last;
	logic        frame_end;
	logic        advance;
	frame_info_t info;
	result_t     res;

	assign frame_end     = valid_s1 && at_last;
	assign advance       = !(frame_end && m_axis_tvalid && !m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1   <= s_axis_tdata[7:0];
			shield_s1 <= s_axis_tdata[8];
		end
	end

	mdsfp_capture u_capture (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.rx_byte (byte_s1),
		.at_last (at_last),
		.info    (info)
	);

	mdsfp_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (frame_end && advance),
		.shield    (shield_s1),
		.info      (info),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.res       (res)
	);

	assign m_axis_tuser = res.frame_status;
	assign m_axis_tdata = {
		2'b00,
		res.overcurrent_state,
		res.undervoltage_state,
		res.overvoltage_state,
		res.drive_version,
		res.fault_code_low,
		res.fault_code_high,
		res.motor_temperature,
		res.module_temperature,
		res.phase_current,
		res.motor_speed
	};

`ifndef NO_ASSERTIONS
	a_held_end: assert property (@(posedge clk) disable iff (!arst_n)
		frame_end && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("stalled frame end byte lost");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser == ST_GOOD || m_axis_tuser == ST_BAD_END
			|| m_axis_tuser == ST_BAD_SUM)
		else $error("bad frame status code");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_GOOD |-> m_axis_tdata[71:0] == 72'd0)
		else $error("bad frame carries data");

	a_trk: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[73:72] != 2'd3 && m_axis_tdata[75:74] != 2'd3
			&& m_axis_tdata[77:76] != 2'd3)
		else $error("tracker out of range");
`endif

endmodule
